// File: design/cmta_pkg.sv
`default_nettype none

package cmta_pkg;

    // default parameter values
    localparam int MAX_FACE_SIZE_DEF = 4096;
    localparam int DIR_BITS_DEF      = 16;

    // fixed field widths
    localparam int CFG_W    = 26;
    localparam int SIZE_W   = 13;
    localparam int STRIDE_W = 26;
    localparam int COORD_W  = 13;
    localparam int TEXEL_W  = 28;
    localparam int FACE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int REG_IDX_W = 2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FACE_STRIDE  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_BUFFER_VALID = 2'd3;

    // register reset values
    localparam logic [SIZE_W-1:0]   RST_IMAGE_WIDTH  = 13'd256;
    localparam logic [SIZE_W-1:0]   RST_IMAGE_HEIGHT = 13'd256;
    localparam logic [STRIDE_W-1:0] RST_FACE_STRIDE  = 26'd87381;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_COPY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_DIR = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd3;

    // face codes
    localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
    localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
    localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

    // control that travels with each word down the pipe
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [FACE_W-1:0]   face;
    } ctrl_t;

endpackage

`default_nettype wire

// File: design/cmta_cell.sv
`default_nettype none

module cmta_cell #(
    parameter int DW  = 17,
    parameter int QW  = 13,
    parameter int RW  = 30,
    parameter int BIT = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cmta_pkg::ctrl_t up_ctrl,
    input  wire logic [RW-1:0]   up_rc,
    input  wire logic [RW-1:0]   up_rr,
    input  wire logic [DW-1:0]   up_den,
    input  wire logic [QW-1:0]   up_qc,
    input  wire logic [QW-1:0]   up_qr,
    output logic                 up_take,
    output cmta_pkg::ctrl_t      dn_ctrl,
    output logic [RW-1:0]        dn_rc,
    output logic [RW-1:0]        dn_rr,
    output logic [DW-1:0]        dn_den,
    output logic [QW-1:0]        dn_qc,
    output logic [QW-1:0]        dn_qr,
    input  wire logic            dn_take
);

    cmta_pkg::ctrl_t   ctrl_reg;
    logic [RW-1:0]     rc_reg, rr_reg, rc_next, rr_next;
    logic [DW-1:0]     den_reg;
    logic [QW-1:0]     qc_reg, qr_reg, qc_next, qr_next;
    logic [RW-1:0]     sub;
    logic              ge_c, ge_r;

    assign up_take = !ctrl_reg.valid || dn_take;

    // one restoring quotient bit for column and row
    always_comb
    begin
        sub     = RW'(up_den) << BIT;
        ge_c    = up_rc >= sub;
        ge_r    = up_rr >= sub;
        rc_next = ge_c ? up_rc - sub : up_rc;
        rr_next = ge_r ? up_rr - sub : up_rr;
        qc_next = up_qc | (QW'(ge_c) << BIT);
        qr_next = up_qr | (QW'(ge_r) << BIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (up_take)
        begin
            ctrl_reg <= up_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_take)
        begin
            rc_reg  <= rc_next;
            rr_reg  <= rr_next;
            den_reg <= up_den;
            qc_reg  <= qc_next;
            qr_reg  <= qr_next;
        end
    end

    assign dn_ctrl = ctrl_reg;
    assign dn_rc   = rc_reg;
    assign dn_rr   = rr_reg;
    assign dn_den  = den_reg;
    assign dn_qc   = qc_reg;
    assign dn_qr   = qr_reg;

endmodule

`default_nettype wire

// File: design/cmta_addr.sv
`default_nettype none

module cmta_addr #(
    parameter int SW = 13
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire cmta_pkg::ctrl_t                 up_ctrl,
    input  wire logic [SW-1:0]                   up_qc,
    input  wire logic [SW-1:0]                   up_qr,
    output logic                                 up_take,
    input  wire logic [SW-1:0]                   w_eff,
    input  wire logic [SW-1:0]                   h_eff,
    input  wire logic [cmta_pkg::STRIDE_W-1:0]   stride,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [cmta_pkg::TEXEL_W-1:0]         texel_index,
    output logic [cmta_pkg::FACE_W-1:0]          face_out,
    output logic [cmta_pkg::STATUS_W-1:0]        status
);

    cmta_pkg::ctrl_t                 c_ctrl_reg;
    logic [cmta_pkg::TEXEL_W-1:0]    c_pf_reg, c_pr_reg, c_col_reg;
    logic                            out_valid_reg;
    logic [cmta_pkg::TEXEL_W-1:0]    texel_reg;
    logic [cmta_pkg::FACE_W-1:0]     face_reg;
    logic [cmta_pkg::STATUS_W-1:0]   status_reg;
    logic [SW-1:0]                   colc, rowc;
    logic [55:0]                     pf, pr;
    logic                            adv_c, adv_d;

    assign adv_d   = !out_valid_reg || !out_stall;
    assign adv_c   = !c_ctrl_reg.valid || adv_d;
    assign up_take = adv_c;

    // clamp to the last texel and form the partial products
    always_comb
    begin
        colc = (up_qc >= w_eff) ? w_eff - SW'(1) : up_qc;
        rowc = (up_qr >= h_eff) ? h_eff - SW'(1) : up_qr;
        pf   = up_ctrl.face * stride;
        pr   = rowc * w_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_ctrl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_c)
            begin
                c_ctrl_reg <= up_ctrl;
            end
            if (adv_d)
            begin
                out_valid_reg <= c_ctrl_reg.valid;
            end
        end
    end

    // product stage
    always_ff @(posedge clk)
    begin
        if (adv_c)
        begin
            c_pf_reg  <= pf[cmta_pkg::TEXEL_W-1:0];
            c_pr_reg  <= pr[cmta_pkg::TEXEL_W-1:0];
            c_col_reg <= cmta_pkg::TEXEL_W'(colc);
        end
    end

    // sum stage, zero address on error
    always_ff @(posedge clk)
    begin
        if (adv_d)
        begin
            texel_reg  <= (c_ctrl_reg.status != cmta_pkg::ST_OK) ? '0
                          : c_pf_reg + c_pr_reg + c_col_reg;
            face_reg   <= c_ctrl_reg.face;
            status_reg <= c_ctrl_reg.status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign texel_index = texel_reg;
    assign face_out    = face_reg;
    assign status      = status_reg;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != cmta_pkg::ST_OK |-> texel_reg == '0 && face_reg == '0)
        else $error("error word carries nonzero address or face");
    a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> face_reg <= cmta_pkg::FACE_NZ)
        else $error("face out of range");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        c_ctrl_reg.valid && out_valid_reg && out_stall |-> !up_take)
        else $error("sum stage overwritten while stalled");
`endif

endmodule

`default_nettype wire

// File: design/cube_map_texel_address_core.sv
`default_nettype none

// pipeline: two input stages, one divider cell per quotient bit and two address stages
// throughput: one word per cycle while out_stall is low; the divider cell chain has one cell per bit
// a stalled output holds the pipe; empty stages still fill behind it
// reset: asynchronous active low, clears valid bits and restores default registers

module cube_map_texel_address_core #(
    parameter int MAX_FACE_SIZE = cmta_pkg::MAX_FACE_SIZE_DEF,
    parameter int DIR_BITS      = cmta_pkg::DIR_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [cmta_pkg::REG_IDX_W-1:0]       cfg_index,
    input  wire logic [cmta_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 mode,
    input  wire logic signed [15:0]                   dir_x,
    input  wire logic signed [15:0]                   dir_y,
    input  wire logic signed [15:0]                   dir_z,
    input  wire logic [cmta_pkg::FACE_W-1:0]          face_in,
    input  wire logic [cmta_pkg::COORD_W-1:0]         col_in,
    input  wire logic [cmta_pkg::COORD_W-1:0]         row_in,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [cmta_pkg::TEXEL_W-1:0]              texel_index,
    output logic [cmta_pkg::FACE_W-1:0]               face_out,
    output logic [cmta_pkg::STATUS_W-1:0]             status
);

    localparam int SW = $clog2(MAX_FACE_SIZE + 1);
    localparam int DW = DIR_BITS + 1;
    localparam int RW = DW + SW;
    localparam int QW = SW;

    // configuration registers
    logic [cmta_pkg::SIZE_W-1:0]   width_reg, height_reg;
    logic [cmta_pkg::STRIDE_W-1:0] stride_reg;
    logic                          bufv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= cmta_pkg::RST_IMAGE_WIDTH;
            height_reg <= cmta_pkg::RST_IMAGE_HEIGHT;
            stride_reg <= cmta_pkg::RST_FACE_STRIDE;
            bufv_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cmta_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[cmta_pkg::SIZE_W-1:0];
                cmta_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data[cmta_pkg::SIZE_W-1:0];
                cmta_pkg::REG_FACE_STRIDE:  stride_reg <= cfg_data;
                cmta_pkg::REG_BUFFER_VALID: bufv_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective face size
    logic [SW-1:0] w_eff, h_eff;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = SW'(1);
        else if (32'(width_reg) > MAX_FACE_SIZE)
            w_eff = SW'(MAX_FACE_SIZE);
        else
            w_eff = SW'(width_reg);
        if (height_reg == '0)
            h_eff = SW'(1);
        else if (32'(height_reg) > MAX_FACE_SIZE)
            h_eff = SW'(MAX_FACE_SIZE);
        else
            h_eff = SW'(height_reg);
    end

    // stage a: face selection and numerators
    logic [47:0]         xw, yw, zw;
    logic [DIR_BITS-1:0] xs, ys, zs, ax, ay, az, m;
    logic [DW-1:0]       xe, ye, ze, me, xp, xm, yp, zp, zm, numc, numr;
    logic                xn, yn, zn, range_bad;
    cmta_pkg::ctrl_t     a_in;

    always_comb
    begin
        xw = {32'd0, dir_x};
        yw = {32'd0, dir_y};
        zw = {32'd0, dir_z};
        xs = xw[DIR_BITS-1:0];
        ys = yw[DIR_BITS-1:0];
        zs = zw[DIR_BITS-1:0];
        xn = xs[DIR_BITS-1];
        yn = ys[DIR_BITS-1];
        zn = zs[DIR_BITS-1];
        ax = xn ? ~xs + DIR_BITS'(1) : xs;
        ay = yn ? ~ys + DIR_BITS'(1) : ys;
        az = zn ? ~zs + DIR_BITS'(1) : zs;
        m  = ax;
        if (ay > m) m = ay;
        if (az > m) m = az;
        xe = {xn, xs};
        ye = {yn, ys};
        ze = {zn, zs};
        me = {1'b0, m};
        xp = me + xe;
        xm = me - xe;
        yp = me + ye;
        zp = me + ze;
        zm = me - ze;
        range_bad = (face_in > cmta_pkg::FACE_NZ) || (32'(col_in) >= 32'(w_eff))
                    || (32'(row_in) >= 32'(h_eff));

        a_in.valid  = in_valid;
        a_in.status = cmta_pkg::ST_OK;
        a_in.face   = cmta_pkg::FACE_PX;
        numc        = '0;
        numr        = '0;
        if (!mode)
        begin
            if (m == '0)
                a_in.status = cmta_pkg::ST_ZERO_DIR;
            else if (!bufv_reg)
                a_in.status = cmta_pkg::ST_NO_COPY;
            else if (ax == m)
            begin
                a_in.face = xn ? cmta_pkg::FACE_PZ : cmta_pkg::FACE_NZ;
                numc      = xn ? zm : zp;
                numr      = yp;
            end
            else if (ay == m)
            begin
                a_in.face = yn ? cmta_pkg::FACE_PY : cmta_pkg::FACE_NY;
                numc      = zm;
                numr      = yn ? xm : xp;
            end
            else
            begin
                a_in.face = zn ? cmta_pkg::FACE_PX : cmta_pkg::FACE_NX;
                numc      = zn ? xp : xm;
                numr      = yp;
            end
        end
        else
        begin
            if (!bufv_reg)
                a_in.status = cmta_pkg::ST_NO_COPY;
            else if (range_bad)
                a_in.status = cmta_pkg::ST_RANGE;
            else
                a_in.face = face_in;
        end
    end

    cmta_pkg::ctrl_t                a_ctrl_reg, b_ctrl_reg;
    logic                           a_mode_reg;
    logic [DW-1:0]                  a_numc_reg, a_numr_reg, a_den_reg, b_den_reg;
    logic [cmta_pkg::COORD_W-1:0]   a_col_reg, a_row_reg;
    logic [RW-1:0]                  b_rc_reg, b_rr_reg, prod_c, prod_r;
    logic                           adv_a, adv_b;
    logic                           chain_take [QW+1];

    assign adv_b    = !b_ctrl_reg.valid || chain_take[0];
    assign adv_a    = !a_ctrl_reg.valid || adv_b;
    assign in_stall = !adv_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctrl_reg <= '0;
            b_ctrl_reg <= '0;
        end
        else
        begin
            if (adv_a)
            begin
                a_ctrl_reg <= a_in;
            end
            if (adv_b)
            begin
                b_ctrl_reg <= a_ctrl_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            a_mode_reg <= mode;
            a_numc_reg <= numc;
            a_numr_reg <= numr;
            a_den_reg  <= {m, 1'b0};
            a_col_reg  <= col_in;
            a_row_reg  <= row_in;
        end
    end

    // stage b: scale numerators by face size, direct words divide by one
    assign prod_c = a_numc_reg * w_eff;
    assign prod_r = a_numr_reg * h_eff;

    always_ff @(posedge clk)
    begin
        if (adv_b)
        begin
            b_rc_reg  <= a_mode_reg ? RW'(a_col_reg) : prod_c;
            b_rr_reg  <= a_mode_reg ? RW'(a_row_reg) : prod_r;
            b_den_reg <= a_mode_reg ? DW'(1) : a_den_reg;
        end
    end

    // divider chain, one quotient bit per cell, msb first
    cmta_pkg::ctrl_t   ch_ctrl [QW+1];
    logic [RW-1:0]     ch_rc   [QW+1];
    logic [RW-1:0]     ch_rr   [QW+1];
    logic [DW-1:0]     ch_den  [QW+1];
    logic [QW-1:0]     ch_qc   [QW+1];
    logic [QW-1:0]     ch_qr   [QW+1];

    assign ch_ctrl[0] = b_ctrl_reg;
    assign ch_rc[0]   = b_rc_reg;
    assign ch_rr[0]   = b_rr_reg;
    assign ch_den[0]  = b_den_reg;
    assign ch_qc[0]   = '0;
    assign ch_qr[0]   = '0;

    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        cmta_cell #(
            .DW  (DW),
            .QW  (QW),
            .RW  (RW),
            .BIT (QW - 1 - i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .up_ctrl (ch_ctrl[i]),
            .up_rc   (ch_rc[i]),
            .up_rr   (ch_rr[i]),
            .up_den  (ch_den[i]),
            .up_qc   (ch_qc[i]),
            .up_qr   (ch_qr[i]),
            .up_take (chain_take[i]),
            .dn_ctrl (ch_ctrl[i+1]),
            .dn_rc   (ch_rc[i+1]),
            .dn_rr   (ch_rr[i+1]),
            .dn_den  (ch_den[i+1]),
            .dn_qc   (ch_qc[i+1]),
            .dn_qr   (ch_qr[i+1]),
            .dn_take (chain_take[i+1])
        );
    end

    // clamp and address
    cmta_addr #(
        .SW (SW)
    ) u_addr (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_ctrl     (ch_ctrl[QW]),
        .up_qc       (ch_qc[QW]),
        .up_qr       (ch_qr[QW]),
        .up_take     (chain_take[QW]),
        .w_eff       (w_eff),
        .h_eff       (h_eff),
        .stride      (stride_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .texel_index (texel_index),
        .face_out    (face_out),
        .status      (status)
    );

endmodule

`default_nettype wire
